FILE: design/aov_pkg.sv
// Shared types and constants for the additive oscillator voice.
// Used by the sequencer, the multiplier and the top level; no dependencies.
`default_nettype none

package aov_pkg;

  // request function codes
  localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WAVE    = 2'd0;
  localparam logic [1:0] CFG_CLASS   = 2'd1;
  localparam logic [1:0] CFG_STEP_HZ = 2'd2;

  // waveform codes
  localparam logic [1:0] WAVE_HARM = 2'd0;
  localparam logic [1:0] WAVE_SAW  = 2'd1;
  localparam logic [1:0] WAVE_SUB  = 2'd2;
  localparam logic [1:0] WAVE_SINE = 2'd3;

  // shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // top octave (notes 120..131) in Hz, Q16
  localparam logic [29:0] FREQ_TOP [12] = '{
    30'd548668577, 30'd581294107, 30'd615859655, 30'd652480569,
    30'd691279090, 30'd732384684, 30'd775934544, 30'd822074013,
    30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
  };

  // 0.15 times class gain, Q16; unknown classes use 0.15
  localparam logic [13:0] CLASS_GAIN [16] = '{
    14'd7864, 14'd9830, 14'd11796, 14'd8847, 14'd10813, 14'd8356, 14'd7864, 14'd8847,
    14'd9339, 14'd8356, 14'd7373, 14'd9830, 14'd9830, 14'd9830, 14'd9830, 14'd9830
  };

  localparam logic [3:0]  CLASS_BASS      = 4'd2;
  localparam logic [6:0]  BASS_NOTE_LIMIT = 7'd60;
  localparam logic [13:0] BASS_LOW_GAIN   = 14'd15335;

  // level = (velocity * gain + 63) / 127, division by reciprocal (2^28 - 1) / 127
  localparam logic [5:0]  LVL_ROUND   = 6'd63;
  localparam logic [6:0]  LVL_DIV     = 7'd127;
  localparam logic [21:0] RECIP_127   = 22'd2113665;
  localparam int          RECIP_SHIFT = 28;
  localparam logic [15:0] LVL_MAX     = 16'd15335;

  // release envelope, Q1.15
  localparam logic [15:0] REL_ONE   = 16'd32768;
  localparam logic [14:0] REL_DECAY = 15'd32440;
  localparam logic [15:0] REL_FLOOR = 16'd163;

  // harmonic weights, Q15
  localparam logic [16:0] W_UNITY  = 17'd32768;
  localparam logic [16:0] W_FUND   = 17'd26214;
  localparam logic [16:0] W_HARM2  = 17'd3277;
  localparam logic [16:0] W_HARM3  = 17'd1638;
  localparam logic [16:0] W_SUBFND = 17'd22938;
  localparam logic [16:0] W_SUB    = 17'd9830;
  localparam logic [16:0] W_ZERO   = 17'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ON_STEP,
    ST_ON_LVL,
    ST_ON_RCP,
    ST_ON_DIV,
    ST_ON_FIX,
    ST_TK_A0,
    ST_TK_A1,
    ST_TK_A2,
    ST_TK_A3,
    ST_TK_SUM,
    ST_TK_LVL,
    ST_TK_REL,
    ST_TK_DEC,
    ST_TK_DONE
  } st_t;

  typedef enum logic [3:0] {
    MS_NONE,
    MS_STEP,
    MS_LEVEL,
    MS_RECIP,
    MS_TAP0,
    MS_TAP1,
    MS_TAP2,
    MS_GAIN,
    MS_REL,
    MS_DECAY
  } mul_sel_t;

  typedef enum logic [1:0] {
    RS_TAP0,
    RS_TAP1,
    RS_TAP2
  } rom_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    rom_sel_t rom_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     ld_step;
    logic     ld_x;
    logic     ld_level;
    logic     ld_samp;
    logic     commit;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: design/additive_oscillator_voice_core.sv
// Top level of the additive oscillator voice: registers, datapath and result stage.
// Depends on aov_pkg, aov_mul, aov_sine_rom and aov_seq.
`default_nettype none

// One DDS synthesizer voice. Every product (phase step, level, level divide by 127,
// harmonic taps, level and release scaling, release decay) goes through a single
// shared 32 x 25 multiplier, and all sine lookups share one registered ROM read port,
// so the sequencer orders the work. A tick on a sounding voice needs the ROM reads,
// three tap products, the level, release and decay products in turn: it passes
// through the tap, sum, level, release and decay states and registers its result
// in the done state. A tick on an idle voice goes straight to the done state, a
// note-on steps through its step, level, reciprocal, divide and fix states, and a
// note-off is handled in idle and leaves the block there. The next request is
// taken once the block is back in idle; a result waiting in the output register
// stalls the following tick only. Configuration writes are accepted every cycle and
// must be made while idle.
module additive_oscillator_voice_core #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic [6:0]         in_note,
  input  wire logic [6:0]         in_velocity,
  input  wire logic               in_allow_tail,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_sample_out,
  output logic                    out_voice_active,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [19:0]        cfg_data
);
  import aov_pkg::*;

  localparam int AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int PB    = PHASE_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int ACC_W = SB + 19;
  localparam int WV_W  = SB + 4;
  localparam int CV_W  = WV_W + 16;
  localparam int LSH   = (SB < 16) ? 16 - SB : 0;
  localparam int RSH   = (SB >= 16) ? SB - 16 : 0;
  localparam logic signed [CV_W-1:0] SAT_HI = CV_W'(32'sd32767);
  localparam logic signed [CV_W-1:0] SAT_LO = CV_W'(-32'sd32768);

  // configuration
  logic [1:0]  cfg_wave_r;
  logic [3:0]  cfg_class_r;
  logic [19:0] cfg_step_hz_r;

  // voice state
  logic [PB:0]   phase_r,      phase_nxt;
  logic [PB-1:0] phase_step_r, phase_step_nxt;
  logic [15:0]   note_level_r, note_level_nxt;
  logic [15:0]   release_r,    release_nxt;
  logic          sounding_r,   sounding_nxt;

  // result stage
  logic                out_valid_r,  out_valid_nxt;
  logic signed [15:0]  out_sample_r, out_sample_nxt;
  logic                out_active_r, out_active_nxt;

  // request payload and datapath registers
  logic [6:0]              note_r;
  logic [6:0]              vel_r;
  logic [20:0]             x_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [15:0]      samp_r;

  ctrl_t ctrl;
  logic  in_fire;
  logic  out_free;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic signed [MUL_P_W-1:0] mul_p_r;

  logic [AW-1:0]          rom_addr;
  logic signed [SB-1:0]   rom_q_r;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  aov_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .sounding (sounding_r),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  aov_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p_r)
  );

  aov_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q_r  (rom_q_r)
  );

  // ---------------- note-on arithmetic ----------------
  logic [12:0] note_x43;
  logic [3:0]  oct;
  logic [3:0]  semi;
  logic [29:0] freq;
  logic [13:0] gain;

  // note / 12 as (note * 43) >> 9, exact for notes up to 127
  assign note_x43 = 13'(note_r) * 13'd43;
  assign oct      = note_x43[12:9];
  assign semi     = 4'(note_r - 7'({3'b000, oct} * 7'd12));
  assign freq     = FREQ_TOP[semi] >> (4'd10 - oct);
  assign gain     = (cfg_class_r == CLASS_BASS && note_r < BASS_NOTE_LIMIT) ?
                    BASS_LOW_GAIN : CLASS_GAIN[cfg_class_r];

  logic [15:0] quo0;
  logic [22:0] quo_x127;
  logic [22:0] rem;
  logic [15:0] level_new;

  // reciprocal quotient is exact or one short; fix with one compare
  assign quo0      = mul_p_r[RECIP_SHIFT +: 16];
  assign quo_x127  = {quo0, 7'b0} - 23'(quo0);
  assign rem       = 23'(x_r) - quo_x127;
  assign level_new = (rem >= 23'(LVL_DIV)) ? quo0 + 16'd1 : quo0;

  // ---------------- tick arithmetic ----------------
  logic [PB-1:0]        ph;
  logic [PB-1:0]        ph3;
  logic signed [SB-1:0] saw;
  logic [16:0]          w0, w1, w2;
  logic signed [WV_W-1:0] wave;
  logic signed [WV_W-1:0] s_lvl;
  logic signed [WV_W-1:0] s_rel;
  logic [15:0]          rel_mul;
  logic signed [CV_W-1:0] s_cv;
  logic signed [15:0]   s_sat;
  logic [15:0]          rel_dec;

  // table entry for a phase fraction: phase * depth, top bits; a plain slice
  // when the depth is a power of two
  function automatic logic [AW-1:0] tbl_index(input logic [PB-1:0] p);
    return AW'((64'(p) * 64'(SINE_TABLE_DEPTH)) >> PB);
  endfunction

  assign ph  = phase_r[PB-1:0];
  assign ph3 = ph + {ph[PB-2:0], 1'b0};
  assign saw = $signed(ph[PB-1 -: SB]);

  always_comb begin
    unique case (ctrl.rom_sel)
      RS_TAP0: rom_addr = tbl_index(ph);
      RS_TAP1: rom_addr = (cfg_wave_r == WAVE_SUB) ? tbl_index(phase_r[PB:1]) :
                                                     tbl_index({ph[PB-2:0], 1'b0});
      RS_TAP2: rom_addr = tbl_index(ph3);
      default: rom_addr = tbl_index(ph);
    endcase
  end

  // three weighted taps per tick; unused taps get weight zero
  always_comb begin
    unique case (cfg_wave_r)
      WAVE_HARM: begin
        w0 = W_FUND;
        w1 = W_HARM2;
        w2 = W_HARM3;
      end
      WAVE_SUB: begin
        w0 = W_SUBFND;
        w1 = W_SUB;
        w2 = W_ZERO;
      end
      default: begin
        w0 = W_UNITY;
        w1 = W_ZERO;
        w2 = W_ZERO;
      end
    endcase
  end

  assign wave    = $signed(acc_r[15 +: WV_W]);
  assign s_lvl   = $signed(mul_p_r[16 +: WV_W]);
  assign s_rel   = $signed(mul_p_r[15 +: WV_W]);
  assign rel_mul = (release_r == 16'd0) ? REL_ONE : release_r;
  assign s_cv    = (CV_W'(s_rel) <<< LSH) >>> RSH;
  assign rel_dec = mul_p_r[15 +: 16];

  always_comb begin
    if (s_cv > SAT_HI) begin
      s_sat = 16'sd32767;
    end else if (s_cv < SAT_LO) begin
      s_sat = -16'sd32768;
    end else begin
      s_sat = s_cv[15:0];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_en = (ctrl.mul_sel != MS_NONE);
    unique case (ctrl.mul_sel)
      MS_STEP: begin
        mul_a = MUL_A_W'(freq);
        mul_b = MUL_B_W'(cfg_step_hz_r);
      end
      MS_LEVEL: begin
        mul_a = MUL_A_W'(vel_r);
        mul_b = MUL_B_W'(gain);
      end
      MS_RECIP: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = MUL_B_W'(RECIP_127);
      end
      MS_TAP0: begin
        mul_a = (cfg_wave_r == WAVE_SAW) ? MUL_A_W'(saw) : MUL_A_W'(rom_q_r);
        mul_b = MUL_B_W'(w0);
      end
      MS_TAP1: begin
        mul_a = MUL_A_W'(rom_q_r);
        mul_b = MUL_B_W'(w1);
      end
      MS_TAP2: begin
        mul_a = MUL_A_W'(rom_q_r);
        mul_b = MUL_B_W'(w2);
      end
      MS_GAIN: begin
        mul_a = MUL_A_W'(wave);
        mul_b = MUL_B_W'(note_level_r);
      end
      MS_REL: begin
        mul_a = MUL_A_W'(s_lvl);
        mul_b = MUL_B_W'(rel_mul);
      end
      MS_DECAY: begin
        mul_a = MUL_A_W'(release_r);
        mul_b = MUL_B_W'(REL_DECAY);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      note_r <= in_note;
      vel_r  <= in_velocity;
    end
    if (ctrl.ld_x) begin
      x_r <= mul_p_r[20:0] + 21'(LVL_ROUND);
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + $signed(mul_p_r[ACC_W-1:0]);
    end
    if (ctrl.ld_samp) begin
      samp_r <= s_sat;
    end
  end

  // ---------------- voice state and result stage ----------------
  always_comb begin
    phase_nxt      = phase_r;
    phase_step_nxt = phase_step_r;
    note_level_nxt = note_level_r;
    release_nxt    = release_r;
    sounding_nxt   = sounding_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;

    if (in_fire && in_func == FUNC_NOTE_OFF) begin
      if (in_allow_tail) begin
        if (sounding_r && release_r == 16'd0) begin
          release_nxt = REL_ONE;
        end
      end else begin
        sounding_nxt   = 1'b0;
        phase_step_nxt = '0;
        release_nxt    = '0;
      end
    end

    if (ctrl.ld_step) begin
      phase_step_nxt = mul_p_r[16 +: PB];
    end

    if (ctrl.ld_level) begin
      note_level_nxt = level_new;
      release_nxt    = '0;
      sounding_nxt   = 1'b1;
    end

    if (ctrl.commit) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = sounding_r ? samp_r : 16'sd0;
      if (sounding_r) begin
        phase_nxt = phase_r + (PB + 1)'(phase_step_r);
        if (release_r != 16'd0) begin
          if (rel_dec <= REL_FLOOR) begin
            sounding_nxt   = 1'b0;
            phase_step_nxt = '0;
            release_nxt    = '0;
          end else begin
            release_nxt = rel_dec;
          end
        end
      end
      out_active_nxt = sounding_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_wave_r    <= WAVE_HARM;
      cfg_class_r   <= 4'd0;
      cfg_step_hz_r <= 20'd89478;
      phase_r       <= '0;
      phase_step_r  <= '0;
      note_level_r  <= '0;
      release_r     <= '0;
      sounding_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_active_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WAVE:    cfg_wave_r    <= cfg_data[1:0];
          CFG_CLASS:   cfg_class_r   <= cfg_data[3:0];
          CFG_STEP_HZ: cfg_step_hz_r <= cfg_data;
          default: begin
            // drop writes beyond the register list
          end
        endcase
      end
      phase_r      <= phase_nxt;
      phase_step_r <= phase_step_nxt;
      note_level_r <= note_level_nxt;
      release_r    <= release_nxt;
      sounding_r   <= sounding_nxt;
      out_valid_r  <= out_valid_nxt;
      out_active_r <= out_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_voice_active = out_active_r;

  // ---------------- assertions ----------------
  a_idle_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    !sounding_r |-> release_r == 16'd0)
    else $error("release gain left set on an idle voice");

  a_release_range: assert property (@(posedge clk) disable iff (!rst_n)
    release_r != 16'd0 |-> (release_r > REL_FLOOR && release_r <= REL_ONE))
    else $error("release gain outside its live range");

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    note_level_r <= LVL_MAX)
    else $error("note level above the largest class gain");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.commit))
    else $error("result shown without a finished tick");

endmodule

`default_nettype wire

FILE: design/aov_mul.sv
// Shared signed multiplier with registered product.
// Depends on aov_pkg for operand widths.
`default_nettype none

module aov_mul (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [aov_pkg::MUL_A_W-1:0]   a,
  input  wire logic signed [aov_pkg::MUL_B_W-1:0]   b,
  output logic signed [aov_pkg::MUL_P_W-1:0]        p_r
);
  import aov_pkg::*;

  logic signed [MUL_P_W-1:0] p_nxt;

  assign p_nxt = MUL_P_W'(a) * MUL_P_W'(b);

  // hold the product while idle so the last result stays readable
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/aov_sine_rom.sv
// Full-cycle sine table, Q1.(SAMPLE_BITS-1), with a registered read port.
// Table contents are generated at elaboration; no package dependency.
`default_nettype none

module aov_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16,
  localparam int ADDR_W          = $clog2(SINE_TABLE_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic [ADDR_W-1:0]             addr,
  output logic signed [SAMPLE_BITS-1:0]      q_r
);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SMP_MAX     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [63:0] RND_HALF    = 64'd1 << (30 - SAMPLE_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] rom_t [SINE_TABLE_DEPTH];

  // quarter-wave Taylor series, mirrored into four quadrants
  function automatic rom_t gen_sine();
    rom_t        tbl;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      q   = (64'd4 * 64'(i)) / SINE_TABLE_DEPTH;
      r   = 64'd4 * 64'(i) - q * SINE_TABLE_DEPTH;
      num = q[0] ? 64'(SINE_TABLE_DEPTH) - r : r;
      x   = HALF_PI_Q30 * num / SINE_TABLE_DEPTH;
      x2  = (x * x) >> 30;
      t   = Q30_ONE - x2 / 110;
      t   = Q30_ONE - ((x2 * t) >> 30) / 72;
      t   = Q30_ONE - ((x2 * t) >> 30) / 42;
      t   = Q30_ONE - ((x2 * t) >> 30) / 20;
      t   = Q30_ONE - ((x2 * t) >> 30) / 6;
      s   = (x * t) >> 30;
      v   = (s + RND_HALF) >> (31 - SAMPLE_BITS);
      if (v > SMP_MAX) begin
        v = SMP_MAX;
      end
      tbl[i] = (q >= 64'd2) ? SAMPLE_BITS'(64'd0 - v) : SAMPLE_BITS'(v);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_TBL = gen_sine();

  always_ff @(posedge clk) begin
    q_r <= SINE_TBL[addr];
  end

endmodule

`default_nettype wire

FILE: design/aov_seq.sv
// Sequencer for the voice: steps note-on and tick requests through the
// shared multiplier and sine ROM. Depends on aov_pkg for st_t and ctrl_t.
`default_nettype none

module aov_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [1:0]  in_func,
  input  wire logic        sounding,
  input  wire logic        out_free,
  output logic             in_ready,
  output aov_pkg::ctrl_t   ctrl
);
  import aov_pkg::*;

  st_t  state_r;
  st_t  state_nxt;
  logic fire;

  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          unique case (in_func)
            FUNC_NOTE_ON: state_nxt = ST_ON_STEP;
            FUNC_TICK:    state_nxt = sounding ? ST_TK_A0 : ST_TK_DONE;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ON_STEP: state_nxt = ST_ON_LVL;
      ST_ON_LVL:  state_nxt = ST_ON_RCP;
      ST_ON_RCP:  state_nxt = ST_ON_DIV;
      ST_ON_DIV:  state_nxt = ST_ON_FIX;
      ST_ON_FIX:  state_nxt = ST_IDLE;
      ST_TK_A0:   state_nxt = ST_TK_A1;
      ST_TK_A1:   state_nxt = ST_TK_A2;
      ST_TK_A2:   state_nxt = ST_TK_A3;
      ST_TK_A3:   state_nxt = ST_TK_SUM;
      ST_TK_SUM:  state_nxt = ST_TK_LVL;
      ST_TK_LVL:  state_nxt = ST_TK_REL;
      ST_TK_REL:  state_nxt = ST_TK_DEC;
      ST_TK_DEC:  state_nxt = ST_TK_DONE;
      ST_TK_DONE: state_nxt = out_free ? ST_IDLE : ST_TK_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl     = '{mul_sel: MS_NONE, rom_sel: RS_TAP0, default: 1'b0};
    unique case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_ON_STEP: ctrl.mul_sel = MS_STEP;
      ST_ON_LVL: begin
        ctrl.ld_step = 1'b1;
        ctrl.mul_sel = MS_LEVEL;
      end
      ST_ON_RCP:  ctrl.ld_x = 1'b1;
      ST_ON_DIV:  ctrl.mul_sel = MS_RECIP;
      ST_ON_FIX:  ctrl.ld_level = 1'b1;
      ST_TK_A0: begin
        ctrl.rom_sel = RS_TAP0;
        ctrl.acc_clr = 1'b1;
      end
      ST_TK_A1: begin
        ctrl.rom_sel = RS_TAP1;
        ctrl.mul_sel = MS_TAP0;
      end
      ST_TK_A2: begin
        ctrl.rom_sel = RS_TAP2;
        ctrl.mul_sel = MS_TAP1;
        ctrl.acc_add = 1'b1;
      end
      ST_TK_A3: begin
        ctrl.mul_sel = MS_TAP2;
        ctrl.acc_add = 1'b1;
      end
      ST_TK_SUM:  ctrl.acc_add = 1'b1;
      ST_TK_LVL:  ctrl.mul_sel = MS_GAIN;
      ST_TK_REL:  ctrl.mul_sel = MS_REL;
      ST_TK_DEC: begin
        ctrl.ld_samp = 1'b1;
        ctrl.mul_sel = MS_DECAY;
      end
      ST_TK_DONE: ctrl.commit = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
